// ===== sv/assert_macros.svh =====
// Assertion helpers included by sat_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SAT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SAT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== sv/sat_pkg.sv =====
`default_nettype none
package sat_pkg;

	localparam int ADDR_W           = 32;
	localparam int COUNT_W          = 5;
	localparam int INDEX_W          = 4;
	localparam int CMD_W            = 2;
	localparam int MAX_SECTIONS_DEF = 16;

	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_V2F   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_F2V   = 2'd2;

	localparam int PADDR_W = 3;
	localparam logic REG_HEADER_SIZE   = 1'b0;
	localparam logic REG_SECTION_COUNT = 1'b1;

	typedef struct packed {
		logic [ADDR_W-1:0] virt;
		logic [ADDR_W-1:0] size;
		logic [ADDR_W-1:0] file;
	} sat_entry_t;

	// controller -> datapath
	typedef struct packed {
		logic take;
		logic rd_en;
		logic load_out;
	} sat_ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic busy;
	} sat_sts_t;

endpackage
`default_nettype wire

// ===== sv/sat_if.sv =====
`default_nettype none
interface sat_in_if;
	logic                         valid;
	logic                         ready;
	logic [sat_pkg::CMD_W-1:0]    command;
	logic [sat_pkg::INDEX_W-1:0]  entry_index;
	logic [sat_pkg::ADDR_W-1:0]   virtual_start;
	logic [sat_pkg::ADDR_W-1:0]   raw_size;
	logic [sat_pkg::ADDR_W-1:0]   raw_offset;
	logic [sat_pkg::ADDR_W-1:0]   query_address;

	modport source (output valid, command, entry_index, virtual_start, raw_size,
		raw_offset, query_address, input ready);
	modport sink (input valid, command, entry_index, virtual_start, raw_size,
		raw_offset, query_address, output ready);
endinterface

interface sat_out_if;
	logic                       valid;
	logic                       ready;
	logic [sat_pkg::ADDR_W-1:0] translated;
	logic                       found;
	logic                       in_headers;

	modport source (output valid, translated, found, in_headers, input ready);
	modport sink (input valid, translated, found, in_headers, output ready);
endinterface
`default_nettype wire

// ===== sv/sat_ctrl.sv =====
`default_nettype none
module sat_ctrl #(
	parameter int MAX_SECTIONS = sat_pkg::MAX_SECTIONS_DEF,
	parameter int CNT_W        = $clog2(MAX_SECTIONS + 1),
	parameter int IDX_W        = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      req_valid,
	input  wire logic [sat_pkg::CMD_W-1:0] req_command,
	output logic                           req_ready,
	output logic                           rsp_valid,
	input  wire logic                      rsp_ready,
	input  wire logic [CNT_W-1:0]          limit,
	input  wire sat_pkg::sat_sts_t         sts,
	output sat_pkg::sat_ctl_t              ctl,
	output logic [IDX_W-1:0]               rd_addr
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_DONE
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] idx_q;
	logic             out_valid_q;

	assign req_ready    = (state_q == S_IDLE);
	assign rsp_valid    = out_valid_q;
	assign rd_addr      = idx_q[IDX_W-1:0];
	assign ctl.take     = req_valid && req_ready;
	assign ctl.rd_en    = (state_q == S_SCAN) && (idx_q < limit);
	assign ctl.load_out = (state_q == S_DONE) && (!out_valid_q || rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (ctl.take) begin
						idx_q <= '0;
						if (req_command == sat_pkg::CMD_V2F || req_command == sat_pkg::CMD_F2V) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_SCAN: begin
					if (ctl.rd_en) begin
						idx_q <= idx_q + CNT_W'(1);
					end else begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!sts.busy) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (ctl.load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== sv/sat_dp.sv =====
`default_nettype none
module sat_dp #(
	parameter int MAX_SECTIONS = sat_pkg::MAX_SECTIONS_DEF,
	parameter int IDX_W        = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire sat_pkg::sat_ctl_t            ctl,
	output sat_pkg::sat_sts_t                 sts,
	input  wire logic [IDX_W-1:0]             rd_addr,
	input  wire logic [sat_pkg::CMD_W-1:0]    command,
	input  wire logic [sat_pkg::INDEX_W-1:0]  entry_index,
	input  wire logic [sat_pkg::ADDR_W-1:0]   virtual_start,
	input  wire logic [sat_pkg::ADDR_W-1:0]   raw_size,
	input  wire logic [sat_pkg::ADDR_W-1:0]   raw_offset,
	input  wire logic [sat_pkg::ADDR_W-1:0]   query_address,
	input  wire logic [sat_pkg::ADDR_W-1:0]   header_size,
	output logic [sat_pkg::ADDR_W-1:0]        translated,
	output logic                              found,
	output logic                              in_headers
);

	localparam int WI_W = IDX_W + sat_pkg::INDEX_W;

	sat_pkg::sat_entry_t mem [MAX_SECTIONS];
	sat_pkg::sat_entry_t rd_q;
	logic                rd_vld_q;

	logic [sat_pkg::CMD_W-1:0]  cmd_q;
	logic [sat_pkg::ADDR_W-1:0] addr_q;
	logic                       hdr_q;

	logic [sat_pkg::ADDR_W-1:0] from_s1, to_s1, end_s1;
	logic                       vld_s1;

	logic                       found_q;
	logic [sat_pkg::ADDR_W-1:0] diff_q, to_q;

	logic [sat_pkg::ADDR_W-1:0] trans_q;
	logic                       found_out_q, hdr_out_q;

	logic [WI_W-1:0] wr_idx;
	logic            wr_en;
	logic            xlate;
	logic            hit_s1;

	assign wr_idx   = {{IDX_W{1'b0}}, entry_index};
	assign wr_en    = ctl.take && (command == sat_pkg::CMD_WRITE)
		&& (wr_idx < WI_W'(MAX_SECTIONS));
	assign xlate    = (cmd_q == sat_pkg::CMD_V2F) || (cmd_q == sat_pkg::CMD_F2V);
	assign hit_s1   = vld_s1 && (from_s1 <= addr_q) && (addr_q < end_s1);
	assign sts.busy = rd_vld_q || vld_s1;

	// section table
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx[IDX_W-1:0]] <= '{virt: virtual_start, size: raw_size, file: raw_offset};
		end
		if (ctl.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// request, entry pipeline, first-hit and output registers (payload)
	always_ff @(posedge clk) begin
		if (ctl.take) begin
			cmd_q  <= command;
			addr_q <= query_address;
			hdr_q  <= (query_address < header_size);
		end
		if (rd_vld_q) begin
			if (cmd_q == sat_pkg::CMD_V2F) begin
				from_s1 <= rd_q.virt;
				to_s1   <= rd_q.file;
				end_s1  <= rd_q.virt + rd_q.size;
			end else begin
				from_s1 <= rd_q.file;
				to_s1   <= rd_q.virt;
				end_s1  <= rd_q.file + rd_q.size;
			end
		end
		if (hit_s1 && !found_q) begin
			diff_q <= addr_q - from_s1;
			to_q   <= to_s1;
		end
		if (ctl.load_out) begin
			if (!xlate) begin
				trans_q     <= '0;
				found_out_q <= 1'b0;
				hdr_out_q   <= 1'b0;
			end else if (hdr_q) begin
				trans_q     <= addr_q;
				found_out_q <= 1'b1;
				hdr_out_q   <= 1'b1;
			end else if (found_q) begin
				trans_q     <= diff_q + to_q;
				found_out_q <= 1'b1;
				hdr_out_q   <= 1'b0;
			end else begin
				trans_q     <= '0;
				found_out_q <= 1'b0;
				hdr_out_q   <= 1'b0;
			end
		end
	end

	// pipeline valids and hit flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_q <= 1'b0;
			vld_s1   <= 1'b0;
			found_q  <= 1'b0;
		end else begin
			rd_vld_q <= ctl.rd_en;
			vld_s1   <= rd_vld_q;
			if (ctl.take) begin
				found_q <= 1'b0;
			end else if (hit_s1) begin
				found_q <= 1'b1;
			end
		end
	end

	assign translated = trans_q;
	assign found      = found_out_q;
	assign in_headers = hdr_out_q;

endmodule
`default_nettype wire

// ===== sv/section_address_translator_core.sv =====
`default_nettype none
// Channel   Role    Word carried
// req       sink    command, entry_index, virtual_start, raw_size, raw_offset, query_address
// rsp       source  translated, found, in_headers
// apb       slave   header_size (0x0), section_count (0x4)
//
// A translate word raises rsp.valid after the scan and the compare pipeline: the table
// is scanned one entry per cycle through its single registered read port, up to
// min(section_count, MAX_SECTIONS) entries, then a two-stage compare pipeline drains.
// A write word or an unused command skips the scan and answers from S_DONE.
// arst_n clears the controller, valid bits and both registers; the table holds
// garbage until written. A stalled rsp holds its word while the next req word
// is taken; a new result waits in the controller until the output is free.
module section_address_translator_core #(
	parameter int MAX_SECTIONS = sat_pkg::MAX_SECTIONS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	sat_in_if.sink                             req,
	sat_out_if.source                          rsp,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [sat_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);

	localparam int CNT_W = $clog2(MAX_SECTIONS + 1);
	localparam int IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
	localparam int SAT_W = (CNT_W > sat_pkg::COUNT_W) ? CNT_W : sat_pkg::COUNT_W;

	logic [sat_pkg::ADDR_W-1:0]  header_size_q;
	logic [sat_pkg::COUNT_W-1:0] section_count_q;
	logic [SAT_W-1:0]            count_ext;
	logic [CNT_W-1:0]            limit;
	logic                        apb_wr;

	sat_pkg::sat_ctl_t ctl;
	sat_pkg::sat_sts_t sts;
	logic [IDX_W-1:0]  rd_addr;

	// Register file: a write lands on the access phase.
	assign pready = 1'b1;
	assign apb_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_size_q   <= '0;
			section_count_q <= '0;
		end else if (apb_wr) begin
			unique case (paddr[2])
				sat_pkg::REG_HEADER_SIZE:   header_size_q   <= pwdata;
				sat_pkg::REG_SECTION_COUNT: section_count_q <= pwdata[sat_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			sat_pkg::REG_HEADER_SIZE:   prdata = header_size_q;
			sat_pkg::REG_SECTION_COUNT: prdata = {{(32 - sat_pkg::COUNT_W){1'b0}}, section_count_q};
			default:                    prdata = '0;
		endcase
	end

	// Cap the scan length at the table depth.
	assign count_ext = SAT_W'(section_count_q);
	assign limit     = (count_ext > SAT_W'(MAX_SECTIONS)) ? CNT_W'(MAX_SECTIONS)
		: count_ext[CNT_W-1:0];

	// Sequencer: accepts a word, walks the table for a translation, hands the result to rsp.
	sat_ctrl #(
		.MAX_SECTIONS (MAX_SECTIONS),
		.CNT_W        (CNT_W),
		.IDX_W        (IDX_W)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req.valid),
		.req_command (req.command),
		.req_ready   (req.ready),
		.rsp_valid   (rsp.valid),
		.rsp_ready   (rsp.ready),
		.limit       (limit),
		.sts         (sts),
		.ctl         (ctl),
		.rd_addr     (rd_addr)
	);

	// Table, window compare and output register.
	sat_dp #(
		.MAX_SECTIONS (MAX_SECTIONS),
		.IDX_W        (IDX_W)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.sts           (sts),
		.rd_addr       (rd_addr),
		.command       (req.command),
		.entry_index   (req.entry_index),
		.virtual_start (req.virtual_start),
		.raw_size      (req.raw_size),
		.raw_offset    (req.raw_offset),
		.query_address (req.query_address),
		.header_size   (header_size_q),
		.translated    (rsp.translated),
		.found         (rsp.found),
		.in_headers    (rsp.in_headers)
	);

endmodule
`default_nettype wire

// ===== sv/sat_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module sat_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        req_valid,
	input wire logic                        req_ready,
	input wire logic                        rsp_valid,
	input wire logic                        rsp_ready,
	input wire logic [sat_pkg::ADDR_W-1:0]  translated,
	input wire logic                        found,
	input wire logic                        in_headers
);

	// a stalled result holds
	`SAT_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(translated) && $stable(found) && $stable(in_headers))
	// a miss, a write or an unused command answers zero
	`SAT_ASSERT_SAME(a_miss_zero, clk, arst_n, rsp_valid && !found, translated == '0)
	// a header hit is always a hit
	`SAT_ASSERT_SAME(a_hdr_found, clk, arst_n, rsp_valid && in_headers, found)
	// one word at a time: never two accepts in a row
	`SAT_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, req_valid && req_ready, !(req_valid && req_ready))

endmodule

bind section_address_translator_core sat_checker u_sat_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.translated (rsp.translated),
	.found      (rsp.found),
	.in_headers (rsp.in_headers)
);
`default_nettype wire

// ===== verif/sat_translation_checker.sv =====
`timescale 1ns / 100ps
module sat_translation_checker #(
	parameter int MAX_SECTIONS = sat_pkg::MAX_SECTIONS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	sat_in_if                                req,
	sat_out_if                               rsp,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic                        pready,
	input  wire logic [sat_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output int                               fail_count,
	output int                               words_pending,
	output int                               words_checked
);

	typedef struct packed {
		logic [sat_pkg::ADDR_W-1:0] translated;
		logic                       found;
		logic                       in_headers;
	} xlat_word_t;

	sat_pkg::sat_entry_t         section_table [MAX_SECTIONS];
	logic [sat_pkg::ADDR_W-1:0]  header_size   = '0;
	logic [sat_pkg::COUNT_W-1:0] section_count = '0;
	xlat_word_t                  expected_words [$];
	int                          failures      = 0;
	int                          checked       = 0;

	initial begin
		fail_count    = 0;
		words_pending = 0;
		words_checked = 0;
	end

	// Apply one word to the shadow table and return the answer it must produce.
	function automatic xlat_word_t predict_translation(
		input logic [sat_pkg::CMD_W-1:0]   cmd,
		input logic [sat_pkg::INDEX_W-1:0] idx,
		input logic [sat_pkg::ADDR_W-1:0]  virt_start,
		input logic [sat_pkg::ADDR_W-1:0]  sec_size,
		input logic [sat_pkg::ADDR_W-1:0]  file_start,
		input logic [sat_pkg::ADDR_W-1:0]  addr
	);
		xlat_word_t                 word;
		int                         searched;
		int                         i;
		logic [sat_pkg::ADDR_W-1:0] win_base;
		logic [sat_pkg::ADDR_W-1:0] win_end;
		logic [sat_pkg::ADDR_W-1:0] other_base;
		logic                       hit;
		word     = '0;
		hit      = 1'b0;
		searched = (section_count > MAX_SECTIONS) ? MAX_SECTIONS : int'(section_count);
		if (cmd == sat_pkg::CMD_WRITE) begin
			if (idx < MAX_SECTIONS)
				section_table[idx] = '{virt: virt_start, size: sec_size, file: file_start};
		end else if (cmd == sat_pkg::CMD_V2F || cmd == sat_pkg::CMD_F2V) begin
			if (addr < header_size) begin
				word = '{translated: addr, found: 1'b1, in_headers: 1'b1};
			end else begin
				for (i = 0; i < searched; i++) begin
					win_base   = (cmd == sat_pkg::CMD_V2F) ? section_table[i].virt
						: section_table[i].file;
					other_base = (cmd == sat_pkg::CMD_V2F) ? section_table[i].file
						: section_table[i].virt;
					win_end    = win_base + section_table[i].size;
					if (!hit && win_base <= addr && addr < win_end) begin
						hit  = 1'b1;
						word = '{translated: (addr - win_base) + other_base, found: 1'b1,
							in_headers: 1'b0};
					end
				end
			end
		end
		return word;
	endfunction

	always @(posedge clk) begin
		xlat_word_t want;
		if (arst_n) begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[sat_pkg::PADDR_W-1:2] == sat_pkg::REG_HEADER_SIZE)
					header_size = pwdata;
				else if (paddr[sat_pkg::PADDR_W-1:2] == sat_pkg::REG_SECTION_COUNT)
					section_count = pwdata[sat_pkg::COUNT_W-1:0];
			end
			// Older words leave before the new one enters.
			if (rsp.valid && rsp.ready) begin
				checked++;
				if (expected_words.size() == 0) begin
					$error("unexpected result word: translated %h found %b in_headers %b",
						rsp.translated, rsp.found, rsp.in_headers);
					failures++;
				end else begin
					want = expected_words.pop_front();
					if (rsp.translated !== want.translated) begin
						$error("translated mismatch: expected %h, actual %h",
							want.translated, rsp.translated);
						failures++;
					end
					if (rsp.found !== want.found) begin
						$error("found mismatch: expected %b, actual %b", want.found, rsp.found);
						failures++;
					end
					if (rsp.in_headers !== want.in_headers) begin
						$error("in_headers mismatch: expected %b, actual %b",
							want.in_headers, rsp.in_headers);
						failures++;
					end
				end
			end
			if (req.valid && req.ready)
				expected_words.push_back(predict_translation(req.command, req.entry_index,
					req.virtual_start, req.raw_size, req.raw_offset, req.query_address));
			fail_count    <= failures;
			words_pending <= expected_words.size();
			words_checked <= checked;
		end
	end

endmodule

// ===== verif/section_address_translator_core_tb.sv =====
`timescale 1ns / 100ps
module section_address_translator_core_tb;

	typedef logic [sat_pkg::INDEX_W-1:0] entry_idx_t;

	// Command code 3 has no name in the package; it must answer all zero.
	localparam logic [sat_pkg::CMD_W-1:0]   CMD_UNUSED         = 2'd3;
	localparam logic [sat_pkg::PADDR_W-1:0] ADDR_HEADER_SIZE   =
		{sat_pkg::REG_HEADER_SIZE, 2'b00};
	localparam logic [sat_pkg::PADDR_W-1:0] ADDR_SECTION_COUNT =
		{sat_pkg::REG_SECTION_COUNT, 2'b00};
	localparam int PHASES          = 7;
	localparam int WORDS_PER_PHASE = 93;
	// A full scan plus the compare pipeline, with margin.
	localparam int DRAIN_CYCLES    = sat_pkg::MAX_SECTIONS_DEF + 16;
	localparam int CYCLE_LIMIT     = 300000;

	logic                        clk     = 1'b0;
	logic                        arst_n  = 1'b0;
	logic                        psel    = 1'b0;
	logic                        penable = 1'b0;
	logic                        pwrite  = 1'b0;
	logic [sat_pkg::PADDR_W-1:0] paddr   = '0;
	logic [31:0]                 pwdata  = '0;
	logic [31:0]                 prdata;
	logic                        pready;
	logic                        idle_on = 1'b1;

	int cycle_count = 0;
	int check_failures;
	int words_pending;
	int words_checked;
	int writes_sent  = 0;
	int queries_sent = 0;
	int unused_sent  = 0;

	// Track what was loaded so translations can be aimed at live windows.
	logic [sat_pkg::ADDR_W-1:0] aim_virt [sat_pkg::MAX_SECTIONS_DEF];
	logic [sat_pkg::ADDR_W-1:0] aim_size [sat_pkg::MAX_SECTIONS_DEF];
	logic [sat_pkg::ADDR_W-1:0] aim_file [sat_pkg::MAX_SECTIONS_DEF];
	logic [sat_pkg::ADDR_W-1:0] cur_header = '0;

	sat_in_if  req_bus ();
	sat_out_if rsp_bus ();

	section_address_translator_core #(
		.MAX_SECTIONS(sat_pkg::MAX_SECTIONS_DEF)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	sat_translation_checker #(
		.MAX_SECTIONS(sat_pkg::MAX_SECTIONS_DEF)
	) xlat_monitor (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req_bus),
		.rsp          (rsp_bus),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.pready       (pready),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.fail_count   (check_failures),
		.words_pending(words_pending),
		.words_checked(words_checked)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Bound the run: a hang in the handshake ends here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$error("cycle limit reached with %0d words outstanding", words_pending);
			$display("Test completed with failures");
			$finish;
		end
	end

	// Result side: while idling is on, sometimes hold ready low for a random burst,
	// otherwise keep it high for a random stretch.
	initial begin
		rsp_bus.ready = 1'b1;
		forever begin
			if (idle_on && $urandom_range(0, 3) == 0) begin
				@(negedge clk);
				rsp_bus.ready = 1'b0;
				repeat ($urandom_range(0, 7)) @(negedge clk);
			end
			@(negedge clk);
			rsp_bus.ready = 1'b1;
			repeat ($urandom_range(0, 15)) @(negedge clk);
		end
	end

	// Register write: setup, then access; pready is waited on anyway.
	task automatic apb_write(input logic [sat_pkg::PADDR_W-1:0] addr,
		input logic [31:0] data);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = addr;
		pwdata  = data;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// Present one word and hold it until accepted. Valid stays high into the
	// next word unless an idle burst drops it first.
	task automatic send_word(
		input logic [sat_pkg::CMD_W-1:0]  cmd,
		input entry_idx_t                 idx,
		input logic [sat_pkg::ADDR_W-1:0] virt_start,
		input logic [sat_pkg::ADDR_W-1:0] sec_size,
		input logic [sat_pkg::ADDR_W-1:0] file_start,
		input logic [sat_pkg::ADDR_W-1:0] addr
	);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			@(negedge clk);
			req_bus.valid = 1'b0;
			repeat ($urandom_range(0, 7)) @(negedge clk);
		end
		@(negedge clk);
		req_bus.valid         = 1'b1;
		req_bus.command       = cmd;
		req_bus.entry_index   = idx;
		req_bus.virtual_start = virt_start;
		req_bus.raw_size      = sec_size;
		req_bus.raw_offset    = file_start;
		req_bus.query_address = addr;
		@(posedge clk);
		while (!req_bus.ready) @(posedge clk);
		if (cmd == sat_pkg::CMD_WRITE) begin
			aim_virt[idx] = virt_start;
			aim_size[idx] = sec_size;
			aim_file[idx] = file_start;
			writes_sent++;
		end else if (cmd == sat_pkg::CMD_V2F || cmd == sat_pkg::CMD_F2V) begin
			queries_sent++;
		end else begin
			unused_sent++;
		end
	endtask

	// Drop valid, wait for every answer, then let the scan pipeline go quiet.
	task automatic drain_words();
		@(negedge clk);
		req_bus.valid = 1'b0;
		while (words_pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		int                         phase;
		int                         n;
		int                         pick;
		int                         aim;
		int                         k;
		int                         count_setting;
		logic [sat_pkg::CMD_W-1:0]  cmd;
		logic [sat_pkg::ADDR_W-1:0] virt_start;
		logic [sat_pkg::ADDR_W-1:0] sec_size;
		logic [sat_pkg::ADDR_W-1:0] file_start;
		logic [sat_pkg::ADDR_W-1:0] win_base;
		logic [sat_pkg::ADDR_W-1:0] addr;

		req_bus.valid         = 1'b0;
		req_bus.command       = sat_pkg::CMD_WRITE;
		req_bus.entry_index   = '0;
		req_bus.virtual_start = '0;
		req_bus.raw_size      = '0;
		req_bus.raw_offset    = '0;
		req_bus.query_address = '0;

		// Hold reset from time zero, release on a falling edge.
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: load every entry before any query can scan it.
		cur_header = 32'h0000_1000;
		apb_write(ADDR_HEADER_SIZE, cur_header);
		apb_write(ADDR_SECTION_COUNT, 32'd16);
		send_word(sat_pkg::CMD_WRITE, 4'd0, 32'h0000_1000, 32'h0000_2000, 32'h0000_0400, '0);
		// zero-size window ahead of a live one at the same base
		send_word(sat_pkg::CMD_WRITE, 4'd1, 32'h0000_4000, 32'h0000_0000, 32'h0000_2400, '0);
		send_word(sat_pkg::CMD_WRITE, 4'd2, 32'h0000_4000, 32'h0000_1000, 32'h0000_2400, '0);
		// overlaps entry 2; the lower index must win
		send_word(sat_pkg::CMD_WRITE, 4'd3, 32'h0000_3000, 32'h0000_1800, 32'h0000_3400, '0);
		// virtual window end wraps past zero, so a V2F lookup can never match it
		send_word(sat_pkg::CMD_WRITE, 4'd4, 32'hFFFF_F000, 32'h0000_2000, 32'h0001_0000, '0);
		// top of the space, result wraps through zero
		send_word(sat_pkg::CMD_WRITE, 4'd5, 32'hFFFF_0000, 32'h0000_FFFF, 32'hFFFF_FF00, '0);
		send_word(sat_pkg::CMD_WRITE, 4'd6, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000, '0);
		send_word(sat_pkg::CMD_WRITE, 4'd7, 32'h0000_0000, 32'hFFFF_FFFF, 32'h1234_5678, '0);
		for (k = 8; k < sat_pkg::MAX_SECTIONS_DEF; k++)
			send_word(sat_pkg::CMD_WRITE, entry_idx_t'(k), $urandom,
				$urandom_range(1, 32'h4000), $urandom, $urandom);
		send_word(sat_pkg::CMD_V2F, '0, '0, '0, '0, 32'h0000_0000);
		send_word(sat_pkg::CMD_V2F, '0, '0, '0, '0, 32'h0000_0FFF);
		send_word(sat_pkg::CMD_V2F, '0, '0, '0, '0, 32'h0000_1000);
		send_word(sat_pkg::CMD_F2V, '0, '0, '0, '0, 32'h0000_23FF);
		send_word(sat_pkg::CMD_F2V, '0, '0, '0, '0, 32'h0000_2400);
		send_word(sat_pkg::CMD_V2F, '0, '0, '0, '0, 32'h0000_4100);
		send_word(sat_pkg::CMD_V2F, '0, '0, '0, '0, 32'hFFFF_FFFE);
		send_word(sat_pkg::CMD_V2F, '0, '0, '0, '0, 32'hFFFF_F800);
		send_word(CMD_UNUSED, '1, '1, '1, '1, '1);
		drain_words();

		// Random part: one register setting per phase, extremes included.
		// Idling pauses for one middle phase and stays off for the last.
		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin
					cur_header    = 32'h0000_0000;
					count_setting = 16;
				end
				1: begin
					cur_header    = 32'hFFFF_FFFF;
					count_setting = 16;
				end
				2: begin
					cur_header    = $urandom_range(0, 32'h3000);
					count_setting = 31;
				end
				3: begin
					cur_header    = 32'h0000_0800;
					count_setting = 0;
				end
				4: begin
					cur_header    = 32'h0000_1000;
					count_setting = 1;
				end
				5: begin
					cur_header    = $urandom_range(0, 32'h0001_0000);
					count_setting = $urandom_range(0, 31);
				end
				default: begin
					cur_header    = 32'h0000_1000;
					count_setting = 16;
				end
			endcase
			idle_on = (phase != 3 && phase != PHASES - 1);
			apb_write(ADDR_HEADER_SIZE, cur_header);
			// Junk in the upper bits must not reach the 5-bit count.
			apb_write(ADDR_SECTION_COUNT, ($urandom & 32'hFFFF_FFE0) | count_setting);

			for (n = 0; n < WORDS_PER_PHASE; n++) begin
				pick = $urandom_range(0, 99);
				k    = $urandom_range(0, sat_pkg::MAX_SECTIONS_DEF - 1);
				if (pick < 12) begin
					virt_start = $urandom;
					file_start = $urandom;
					case ($urandom_range(0, 6))
						0: sec_size = $urandom;
						1: sec_size = '0;
						2: begin
							// push the window across the top of the space
							sec_size   = $urandom_range(1, 32'h0001_0000);
							virt_start = 32'hFFFF_FFFF - $urandom_range(0, 32'h8000);
						end
						default: sec_size = $urandom_range(1, 32'h4000);
					endcase
					send_word(sat_pkg::CMD_WRITE, entry_idx_t'(k), virt_start, sec_size,
						file_start, $urandom);
				end else if (pick < 16) begin
					send_word(CMD_UNUSED, entry_idx_t'($urandom), $urandom, $urandom,
						$urandom, $urandom);
				end else begin
					cmd      = $urandom_range(0, 1) ? sat_pkg::CMD_V2F : sat_pkg::CMD_F2V;
					win_base = (cmd == sat_pkg::CMD_V2F) ? aim_virt[k] : aim_file[k];
					aim      = $urandom_range(0, 9);
					// Mostly land inside a window or on its edges; some near the
					// header boundary, the rest anywhere.
					if (aim < 4)
						addr = win_base + ((aim_size[k] == 0) ? '0 : $urandom % aim_size[k]);
					else if (aim == 4)
						addr = win_base;
					else if (aim == 5)
						addr = win_base + aim_size[k] - 1;
					else if (aim == 6)
						addr = win_base + aim_size[k];
					else if (aim == 7)
						addr = cur_header - 1 + $urandom_range(0, 2);
					else
						addr = $urandom;
					send_word(cmd, entry_idx_t'($urandom), $urandom, $urandom, $urandom, addr);
				end
			end
			drain_words();
		end

		$display("Covered %0d section loads, %0d translations and %0d unused commands",
			writes_sent, queries_sent, unused_sent);
		$display("Compared %0d result words across %0d register settings",
			words_checked, PHASES + 1);
		if (check_failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+sv
sv/sat_pkg.sv
sv/sat_if.sv
sv/sat_ctrl.sv
sv/sat_dp.sv
sv/section_address_translator_core.sv
sv/sat_checker.sv
verif/sat_translation_checker.sv
verif/section_address_translator_core_tb.sv
